// ===== sv/gscs_pkg.sv =====
// ----------------------------------------------------------------------------
// gscs_pkg
// Shared types and constants of the gear-shift clutch sequencer.
// ----------------------------------------------------------------------------
package gscs_pkg;

	localparam int MaxGears = 16;
	localparam logic [3:0] GearTop = 4'(MaxGears - 1);

	localparam int QuotBits = 10;
	localparam int NumBits = 16;
	localparam int ProdBits = NumBits + QuotBits;
	localparam logic [QuotBits-1:0] ClutchFull = 10'd1000;

	localparam int SDataW = 40;
	localparam int MDataW = 24;

	localparam logic [3:0] GearNeutral = 4'd0;
	localparam logic [3:0] GearReverse = 4'd1;
	localparam logic [3:0] GearFirst = 4'd2;

	typedef enum logic [1:0] {
		CFG_GEAR_COUNT = 2'd0,
		CFG_DECLUTCH = 2'd1,
		CFG_RECLUTCH = 2'd2,
		CFG_ASSIST = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_DECIDE,
		ST_LOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [3:0] gear_count;
		logic [15:0] declutch_time_ms;
		logic [15:0] reclutch_time_ms;
		logic auto_clutch_assist;
	} cfg_t;

	typedef struct packed {
		logic kind;
		logic [31:0] now_ms;
		logic shift_up;
		logic shift_down;
	} in_item_t;

	typedef struct packed {
		logic [3:0] gear;
		logic [3:0] target_gear;
		logic shifting;
		logic gear_changed;
		logic clutch_valid;
		logic [9:0] clutch_per_mille;
		logic auto_clutch_active;
	} result_t;

	typedef struct packed {
		logic start;
		logic [NumBits-1:0] num;
		logic [NumBits-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [QuotBits-1:0] quot;
	} div_rsp_t;

endpackage

// ===== sv/gscs_div.sv =====
// ----------------------------------------------------------------------------
// gscs_div
// Per-mille ratio num*1000/den, one quotient bit per cycle (restoring).
// ----------------------------------------------------------------------------
module gscs_div import gscs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);

	localparam int CntW = $clog2(QuotBits);

	logic [NumBits-1:0] rem_q;
	logic [NumBits-1:0] den_q;
	logic [QuotBits-1:0] low_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [ProdBits-1:0] prod;
	logic [NumBits:0] shifted;
	logic [NumBits:0] diff;
	logic geq;

	assign prod = ProdBits'(req.num) * ProdBits'(ClutchFull);
	assign shifted = {rem_q, low_q[QuotBits-1]};
	assign geq = shifted >= {1'b0, den_q};
	assign diff = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(QuotBits - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= prod[ProdBits-1:QuotBits];
			low_q <= prod[QuotBits-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= geq ? diff[NumBits-1:0] : shifted[NumBits-1:0];
			low_q <= {low_q[QuotBits-2:0], geq};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = low_q;

endmodule

// ===== sv/gscs_core.sv =====
// ----------------------------------------------------------------------------
// gscs_core
// Shift sequencer: gear state, phase decisions and clutch ramp control.
// ----------------------------------------------------------------------------
module gscs_core import gscs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_item,
	input cfg_t cfg,
	output logic res_valid,
	input logic res_ready,
	output result_t res
);

	state_t state_q, state_d;

	in_item_t item_q;
	logic [31:0] t_q;
	logic [3:0] cur_gear_q;
	logic [3:0] next_gear_q;
	logic busy_q;
	logic auto_on_q;
	logic [31:0] start_q;
	logic changed_q;
	logic cvalid_q;
	logic invert_q;
	logic [9:0] clutch_q;
	logic [15:0] num_q;
	logic [15:0] den_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [3:0] top_gear;
	logic [3:0] up_gear;
	logic [3:0] down_gear;
	logic ac;
	logic tick_busy;
	logic phase_declutch;
	logic t_ge_dt;
	logic t_ge_end;
	logic rt_zero;
	logic [16:0] end_time;
	logic [15:0] excess;
	logic need_div;

	gscs_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign top_gear = (cfg.gear_count > GearTop) ? GearTop : cfg.gear_count;
	assign ac = cfg.auto_clutch_assist;
	assign tick_busy = !item_q.kind && busy_q;
	assign phase_declutch = cur_gear_q != next_gear_q;
	assign end_time = {1'b0, cfg.declutch_time_ms} + {1'b0, cfg.reclutch_time_ms};
	assign t_ge_dt = t_q >= 32'(cfg.declutch_time_ms);
	assign t_ge_end = t_q >= 32'(end_time);
	assign rt_zero = cfg.reclutch_time_ms == '0;
	assign excess = (t_q > 32'(cfg.declutch_time_ms)) ?
		16'(t_q - 32'(cfg.declutch_time_ms)) : '0;
	assign need_div = tick_busy && ac &&
		(phase_declutch ? !t_ge_dt : (!t_ge_end && !rt_zero));

	always_comb begin
		priority if (cur_gear_q == GearNeutral) up_gear = GearFirst;
		else if (cur_gear_q == GearReverse) up_gear = GearNeutral;
		else up_gear = cur_gear_q + 4'd1;
		priority if (cur_gear_q == GearNeutral) down_gear = GearReverse;
		else if (cur_gear_q == GearReverse) down_gear = GearReverse;
		else if (cur_gear_q == GearFirst) down_gear = GearNeutral;
		else down_gear = cur_gear_q - 4'd1;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DIFF;
			ST_DIFF: state_d = ST_DECIDE;
			ST_DECIDE: state_d = need_div ? ST_LOAD : ST_FIN;
			ST_LOAD: state_d = ST_DIV;
			ST_DIV: if (div_rsp.done) state_d = ST_FIN;
			ST_FIN: if (res_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = state_q == ST_IDLE;
		res_valid = state_q == ST_FIN;
		div_req.start = state_q == ST_LOAD;
		div_req.num = num_q;
		div_req.den = den_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cur_gear_q <= GearNeutral;
			next_gear_q <= GearNeutral;
			busy_q <= 1'b0;
			start_q <= '0;
			auto_on_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DECIDE) begin
				if (item_q.kind) begin
					if (!busy_q) begin
						if (item_q.shift_up) begin
							if (cur_gear_q < top_gear) begin
								busy_q <= 1'b1;
								start_q <= item_q.now_ms;
								next_gear_q <= up_gear;
							end
						end else if (item_q.shift_down) begin
							busy_q <= 1'b1;
							start_q <= item_q.now_ms;
							next_gear_q <= down_gear;
						end
					end
				end else if (busy_q) begin
					if (ac) auto_on_q <= 1'b1;
					if (phase_declutch) begin
						if (t_ge_dt) cur_gear_q <= next_gear_q;
					end else if (t_ge_end) begin
						busy_q <= 1'b0;
						if (ac) auto_on_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_q <= in_item;
		if (state_q == ST_DIFF) t_q <= item_q.now_ms - start_q;
		if (state_q == ST_DECIDE) begin
			changed_q <= tick_busy && phase_declutch && t_ge_dt;
			cvalid_q <= tick_busy && ac;
			if (tick_busy && ac &&
			    ((phase_declutch && t_ge_dt) || (!phase_declutch && !t_ge_end && rt_zero)))
				clutch_q <= ClutchFull;
			else
				clutch_q <= '0;
			num_q <= phase_declutch ? t_q[15:0] : excess;
			den_q <= phase_declutch ? cfg.declutch_time_ms : cfg.reclutch_time_ms;
			invert_q <= !phase_declutch;
		end
		if (state_q == ST_DIV && div_rsp.done)
			clutch_q <= invert_q ? ClutchFull - div_rsp.quot : div_rsp.quot;
	end

	assign res.gear = cur_gear_q;
	assign res.target_gear = next_gear_q;
	assign res.shifting = busy_q;
	assign res.gear_changed = changed_q;
	assign res.clutch_valid = cvalid_q;
	assign res.clutch_per_mille = clutch_q;
	assign res.auto_clutch_active = auto_on_q;

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_gear_change_in_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_gear_q != $past(cur_gear_q)) |-> $past(state_q == ST_DECIDE))
		else $error("gear changed outside decision step");

	a_clutch_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> clutch_q <= ClutchFull)
		else $error("clutch command above full scale");

	a_clutch_zero_unless_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !cvalid_q) |-> clutch_q == '0)
		else $error("clutch value without valid");

endmodule

// ===== sv/gear_shift_clutch_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// gear_shift_clutch_sequencer_top
// Timed gear-shift sequencer with automatic clutch ramp.
//
// Input stream: one transaction per item; tuser is the kind (0 tick, 1 poll),
// tdata carries the time and the shift requests. Every input transaction
// yields exactly one output transaction with gear, target, shift status and
// the clutch command.
// Items are handled one at a time. A poll or an idle tick passes through the
// DIFF and DECIDE states to FIN; a tick that ramps the clutch also passes
// through LOAD and DIV, where the 10-step bit-serial per-mille divider runs.
// The output register decouples the sides: the next item is accepted while a
// finished result still waits for the receiver. If the receiver stalls with
// the output register full, the finished result waits in the core and input
// tready stays low.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset: neutral gear, no shift running, registers at 4, 500, 500, 0.
// ----------------------------------------------------------------------------
module gear_shift_clutch_sequencer_top import gscs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_addr,
	input logic [15:0] cfg_wdata,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [SDataW-1:0] s_axis_tdata, // now_ms[31:0], shift_up, shift_down
	input logic s_axis_tuser, // kind
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// gear[3:0], target_gear[7:4], shifting, gear_changed, clutch_valid,
	// clutch_per_mille[20:11], auto_clutch_active, zero fill
	output logic [MDataW-1:0] m_axis_tdata
);

	cfg_t cfg_q;
	in_item_t in_item;
	result_t res;
	logic res_valid;
	logic res_ready;
	logic out_valid_q;
	logic [MDataW-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gear_count <= 4'd4;
			cfg_q.declutch_time_ms <= 16'd500;
			cfg_q.reclutch_time_ms <= 16'd500;
			cfg_q.auto_clutch_assist <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				CFG_GEAR_COUNT: cfg_q.gear_count <= cfg_wdata[3:0];
				CFG_DECLUTCH: cfg_q.declutch_time_ms <= cfg_wdata;
				CFG_RECLUTCH: cfg_q.reclutch_time_ms <= cfg_wdata;
				CFG_ASSIST: cfg_q.auto_clutch_assist <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign in_item.kind = s_axis_tuser;
	assign in_item.now_ms = s_axis_tdata[31:0];
	assign in_item.shift_up = s_axis_tdata[32];
	assign in_item.shift_down = s_axis_tdata[33];

	gscs_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_item(in_item),
		.cfg(cfg_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			out_data_q <= {2'b00, res.auto_clutch_active, res.clutch_per_mille,
				res.clutch_valid, res.gear_changed, res.shifting,
				res.target_gear, res.gear};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

endmodule
